// ===== src/nnd_pkg.sv =====
// Shared types and constants for the nearest-neighbor downscaler.
`timescale 1ns / 1ps

package nnd_pkg;

  // Width of every size register on the configuration port.
  localparam int CFG_W = 14;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Default largest frame dimension handled by the counters.
  localparam int MAX_DIMENSION_DEF = 8192;

  // Register values after reset.
  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = CFG_W'(1080);
  localparam logic [CFG_W-1:0] TARGET_WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] TARGET_HEIGHT_RST = CFG_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // Decision for one source pixel, passed from the selector to the top level.
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } sel_t;

endpackage

// ===== src/nnd_select.sv =====
// Column and row selection counters and accumulators of the downscaler.
`timescale 1ns / 1ps

module nnd_select #(
  parameter int MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic                               start,
  input  logic [$clog2(MAX_DIMENSION+1)-1:0] sw,
  input  logic [$clog2(MAX_DIMENSION+1)-1:0] sh,
  input  logic [$clog2(MAX_DIMENSION+1)-1:0] tw,
  input  logic [$clog2(MAX_DIMENSION+1)-1:0] th,
  output nnd_pkg::sel_t                      sel
);
  import nnd_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION + 1);
  localparam int AW = $clog2(MAX_DIMENSION * MAX_DIMENSION + MAX_DIMENSION + 1);

  logic [CW-1:0] src_col, src_row, dst_col, dst_row;
  logic [CW-1:0] src_col_next, src_row_next, dst_col_next, dst_row_next;
  logic [AW-1:0] col_target_accum, col_base_accum, row_target_accum, row_base_accum;
  logic [AW-1:0] col_target_accum_next, col_base_accum_next;
  logic [AW-1:0] row_target_accum_next, row_base_accum_next;

  // Values seen by this pixel: a frame start clears everything first.
  logic [CW-1:0] c_src_col, c_src_row, c_dst_col, c_dst_row;
  logic [AW-1:0] c_col_t, c_col_b, c_row_t, c_row_b;
  logic [CW:0]   src_col_inc, src_row_inc, dst_col_inc, dst_row_inc;
  logic [AW:0]   col_limit, row_limit;
  logic          row_sel, col_sel, emit, last_col, last_row;

  always_comb begin
    c_src_col = start ? '0 : src_col;
    c_src_row = start ? '0 : src_row;
    c_dst_col = start ? '0 : dst_col;
    c_dst_row = start ? '0 : dst_row;
    c_col_t   = start ? '0 : col_target_accum;
    c_col_b   = start ? '0 : col_base_accum;
    c_row_t   = start ? '0 : row_target_accum;
    c_row_b   = start ? '0 : row_base_accum;

    src_col_inc = {1'b0, c_src_col} + (CW+1)'(1);
    src_row_inc = {1'b0, c_src_row} + (CW+1)'(1);
    dst_col_inc = {1'b0, c_dst_col} + (CW+1)'(1);
    dst_row_inc = {1'b0, c_dst_row} + (CW+1)'(1);

    // A pixel is picked when the output position scaled by the source size
    // falls inside the span covered by this source pixel.
    row_limit = {1'b0, c_row_b} + (AW+1)'(th);
    col_limit = {1'b0, c_col_b} + (AW+1)'(tw);
    row_sel   = (c_dst_row < th) && ({1'b0, c_row_t} < row_limit);
    col_sel   = (c_dst_col < tw) && ({1'b0, c_col_t} < col_limit);
    emit      = row_sel && col_sel;

    sel.emit      = emit;
    sel.row_end   = dst_col_inc >= (CW+1)'(tw);
    sel.frame_end = sel.row_end && (dst_row_inc >= (CW+1)'(th));

    last_col = src_col_inc >= (CW+1)'(sw);
    last_row = src_row_inc >= (CW+1)'(sh);

    src_row_next          = c_src_row;
    dst_row_next          = c_dst_row;
    row_target_accum_next = c_row_t;
    row_base_accum_next   = c_row_b;

    if (!last_col) begin
      src_col_next          = src_col_inc[CW-1:0];
      col_base_accum_next   = c_col_b + AW'(tw);
      dst_col_next          = emit ? dst_col_inc[CW-1:0] : c_dst_col;
      col_target_accum_next = emit ? c_col_t + AW'(sw) : c_col_t;
    end else begin
      src_col_next          = '0;
      col_base_accum_next   = '0;
      dst_col_next          = '0;
      col_target_accum_next = '0;
      if (last_row) begin
        src_row_next          = '0;
        dst_row_next          = '0;
        row_target_accum_next = '0;
        row_base_accum_next   = '0;
      end else begin
        if (row_sel) begin
          dst_row_next          = dst_row_inc[CW-1:0];
          row_target_accum_next = c_row_t + AW'(sh);
        end
        src_row_next        = src_row_inc[CW-1:0];
        row_base_accum_next = c_row_b + AW'(th);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col          <= '0;
      src_row          <= '0;
      dst_col          <= '0;
      dst_row          <= '0;
      col_target_accum <= '0;
      col_base_accum   <= '0;
      row_target_accum <= '0;
      row_base_accum   <= '0;
    end else if (step) begin
      src_col          <= src_col_next;
      src_row          <= src_row_next;
      dst_col          <= dst_col_next;
      dst_row          <= dst_row_next;
      col_target_accum <= col_target_accum_next;
      col_base_accum   <= col_base_accum_next;
      row_target_accum <= row_target_accum_next;
      row_base_accum   <= row_base_accum_next;
    end
  end

endmodule

// ===== src/nearest_neighbor_downscaler.sv =====
// Top level of the nearest-neighbor downscaler for raster-order BGRA pixels.
`timescale 1ns / 1ps

// Usage:
// Source pixels enter on the src channel (src_valid / src_ready) in raster
// order, one per transfer, with frame_start high on the first pixel of a
// frame. Each source pixel yields zero or one pixel on the dst channel
// (dst_valid / dst_ready); row_end and frame_end mark the last pixel of an
// output row and of the output frame.
// Sizes are written on the cfg port (cfg_we, cfg_index, cfg_data) while the
// stream is idle; a zero size acts as one, and target sizes are clamped to
// the source sizes.
// A selected pixel passes through the input register and then the output
// register before it is offered on dst. Throughput: one source pixel per
// cycle while the receiver does not stall, set by the combinational
// add-and-compare step of the column and row accumulators.
// When the receiver stalls, the result stays in the output register and one
// more source pixel is held in the input register; src_ready then drops.
// A pixel that is not selected also waits until the output register is empty
// or draining before it moves on. Reset empties both registers, clears
// all counters and restores the sizes to 1920 by 1080.

module nearest_neighbor_downscaler #(
  parameter int MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           src_valid,
  output logic                           src_ready,
  input  logic [31:0]                    pixel_in,
  input  logic                           frame_start,
  output logic                           dst_valid,
  input  logic                           dst_ready,
  output logic [31:0]                    pixel_out,
  output logic                           row_end,
  output logic                           frame_end
);
  import nnd_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION + 1);

  // Size registers as written.
  logic [CFG_W-1:0] source_width, source_height, target_width, target_height;

  // Effective sizes after the zero and oversize rules.
  logic [CW-1:0] sw, sh, tw, th;

  // Input register stage.
  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic        s1_start;

  logic advance;
  sel_t sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RST;
      source_height <= SOURCE_HEIGHT_RST;
      target_width  <= TARGET_WIDTH_RST;
      target_height <= TARGET_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_TARGET_WIDTH:  target_width  <= cfg_data;
        REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Source sizes are limited to the counter range; target sizes are then
  // limited to the effective source sizes, so the block never upscales.
  always_comb begin
    if (source_width == '0) begin
      sw = CW'(1);
    end else if (32'(source_width) > 32'(MAX_DIMENSION)) begin
      sw = CW'(MAX_DIMENSION);
    end else begin
      sw = CW'(source_width);
    end

    if (source_height == '0) begin
      sh = CW'(1);
    end else if (32'(source_height) > 32'(MAX_DIMENSION)) begin
      sh = CW'(MAX_DIMENSION);
    end else begin
      sh = CW'(source_height);
    end

    if (target_width == '0) begin
      tw = CW'(1);
    end else if (32'(target_width) > 32'(sw)) begin
      tw = sw;
    end else begin
      tw = CW'(target_width);
    end

    if (target_height == '0) begin
      th = CW'(1);
    end else if (32'(target_height) > 32'(sh)) begin
      th = sh;
    end else begin
      th = CW'(target_height);
    end
  end

  // The held pixel is processed whenever the output register can take a
  // result, whether or not this pixel is selected.
  assign advance   = s1_valid && (!dst_valid || dst_ready);
  assign src_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      s1_pixel <= pixel_in;
      s1_start <= frame_start;
    end
  end

  nnd_select #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_select (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .start (s1_start),
    .sw    (sw),
    .sh    (sh),
    .tw    (tw),
    .th    (th),
    .sel   (sel)
  );

  // Output register: loaded with the pixel when it is selected, emptied
  // when its transfer completes with nothing new behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= sel.emit;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sel.emit) begin
      pixel_out <= s1_pixel;
      row_end   <= sel.row_end;
      frame_end <= sel.frame_end;
    end
  end

`ifndef NO_ASSERTIONS
  // The end of a frame is always also the end of an output row.
  a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (!frame_end || row_end))
    else $error("frame_end without row_end");

  // With the output register empty, the block must take a new pixel.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !dst_valid |-> src_ready)
    else $error("src_ready low while output register is empty");

  // Back pressure on src comes only from a stalled result on dst.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (s1_valid && dst_valid && !dst_ready))
    else $error("src_ready low without a stalled result");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the nearest-neighbor downscaler with its own pixel predictor.
`timescale 1ns / 1ps

module testbench;
  import nnd_pkg::*;

  // Largest frame dimension; sizes above it act as this value.
  localparam int MAX_DIM = MAX_DIMENSION_DEF;
  // A selected pixel leaves through the input and output registers after its
  // transfer; wait for it before touching the size registers or ending the run.
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 10;
  // Length of the long receiver hold-off used to fill the block.
  localparam int HOLD_LEN = 200;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Only the first mismatches are printed; all of them are counted.
  localparam int MAX_PRINTS = 40;

  // Receiver behavior during one stretch of its pattern.
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;
  // Shape of one frame in the random part.
  typedef enum int {FRAME_FULL, FRAME_CUT, FRAME_NO_START, FRAME_NO_START_CUT} frame_kind_t;

  // One output pixel with its marks.
  typedef struct packed {
    logic [31:0] pixel;
    logic        row_end;
    logic        frame_end;
  } out_pixel_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // Every input of the block starts at a known value.
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_SOURCE_WIDTH;
  logic [13:0] cfg_data = '0;
  logic        src_valid = 1'b0;
  logic        src_ready;
  logic [31:0] pixel_in = '0;
  logic        frame_start = 1'b0;
  logic        dst_valid;
  logic        dst_ready = 1'b0;
  logic [31:0] pixel_out;
  logic        row_end;
  logic        frame_end;

  nearest_neighbor_downscaler #(
    .MAX_DIMENSION(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .pixel_in(pixel_in),
    .frame_start(frame_start),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .pixel_out(pixel_out),
    .row_end(row_end),
    .frame_end(frame_end)
  );

  // Predictor copy of the size registers, held as raw register values.
  logic [13:0] reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;

  // Predictor position state. Counters need 14 bits to hold 8192, and the
  // accumulators need room for 8192 squared plus a size.
  logic [14:0] src_col, src_row, out_col, out_row;
  logic [27:0] src_col_acc, out_col_acc, src_row_acc, out_row_acc;

  // Output pixels predicted but not yet seen on the dst channel, oldest first.
  out_pixel_t expected_pixels[$];

  // Run statistics.
  int errors = 0;
  int mismatch_prints = 0;
  int pixels_accepted = 0;
  int results_checked = 0;
  int rows_seen = 0;
  int frames_seen = 0;
  int settings_used = 0;
  int hold_count = 0;

  // Sender burst state and the hold-off request for the receiver.
  int burst_left = 0;
  int gap_max = 0;
  bit hold_req = 1'b0;

  // A zero size acts as one and anything above the limit acts as the limit.
  function automatic logic [14:0] clamp_dim(input logic [13:0] v, input logic [14:0] hi);
    if (v == 0) return 15'd1;
    if ({1'b0, v} > hi) return hi;
    return {1'b0, v};
  endfunction

  function automatic void clear_position();
    src_col = '0;
    src_row = '0;
    out_col = '0;
    out_row = '0;
    src_col_acc = '0;
    out_col_acc = '0;
    src_row_acc = '0;
    out_row_acc = '0;
  endfunction

  // Works out what one accepted source pixel produces and advances the position.
  // Column c is taken for output column k when k*W lies in [c*w, (c+1)*w); the
  // accumulators hold those products so no division is needed. Rows work alike.
  function automatic void predict_pixel(input logic [31:0] pix, input logic fs);
    logic [14:0] sw, sh, tw, th;
    logic row_pick, col_pick;
    out_pixel_t res;
    sw = clamp_dim(reg_src_w, 15'(MAX_DIM));
    sh = clamp_dim(reg_src_h, 15'(MAX_DIM));
    // Upscale requests are clamped to the effective source size.
    tw = clamp_dim(reg_dst_w, sw);
    th = clamp_dim(reg_dst_h, sh);
    if (fs) clear_position();
    row_pick = (out_row < th) && (out_row_acc < src_row_acc + th);
    col_pick = (out_col < tw) && (out_col_acc < src_col_acc + tw);
    if (row_pick && col_pick) begin
      res.pixel = pix;
      res.row_end = (out_col + 1 >= tw);
      res.frame_end = res.row_end && (out_row + 1 >= th);
      expected_pixels.push_back(res);
      out_col = out_col + 1;
      out_col_acc = out_col_acc + sw;
    end
    // The wrap tests use >=, so a position left beyond a smaller new size
    // wraps at once.
    if (src_col + 1 < sw) begin
      src_col = src_col + 1;
      src_col_acc = src_col_acc + tw;
    end else begin
      src_col = '0;
      src_col_acc = '0;
      out_col = '0;
      out_col_acc = '0;
      if (src_row + 1 >= sh) begin
        src_row = '0;
        src_row_acc = '0;
        out_row = '0;
        out_row_acc = '0;
      end else begin
        if (row_pick) begin
          out_row = out_row + 1;
          out_row_acc = out_row_acc + sh;
        end
        src_row = src_row + 1;
        src_row_acc = src_row_acc + th;
      end
    end
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (mismatch_prints < MAX_PRINTS) begin
      mismatch_prints++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // All sampling happens at the rising edge, before the nonblocking updates of
  // that edge land, so the values seen are the ones the block saw.
  always @(posedge clk) begin : monitor
    out_pixel_t want;
    if (rst) begin
      reg_src_w = SOURCE_WIDTH_RST;
      reg_src_h = SOURCE_HEIGHT_RST;
      reg_dst_w = TARGET_WIDTH_RST;
      reg_dst_h = TARGET_HEIGHT_RST;
      clear_position();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  reg_src_w = cfg_data;
          REG_SOURCE_HEIGHT: reg_src_h = cfg_data;
          REG_TARGET_WIDTH:  reg_dst_w = cfg_data;
          REG_TARGET_HEIGHT: reg_dst_h = cfg_data;
          default: ;
        endcase
      end
      // The prediction goes first so that a result appearing in the same cycle as
      // its source transfer would still find its expectation.
      if (src_valid && src_ready) begin
        pixels_accepted++;
        predict_pixel(pixel_in, frame_start);
      end
      if (dst_valid && dst_ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (mismatch_prints < MAX_PRINTS) begin
            mismatch_prints++;
            $display("%0t: output pixel %h (row_end %b, frame_end %b) with none expected",
                     $time, pixel_out, row_end, frame_end);
          end
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (want.row_end) rows_seen++;
          if (want.frame_end) frames_seen++;
          if (pixel_out !== want.pixel) note_mismatch("pixel_out", want.pixel, pixel_out);
          if (row_end !== want.row_end) note_mismatch("row_end", want.row_end, row_end);
          if (frame_end !== want.frame_end)
            note_mismatch("frame_end", want.frame_end, frame_end);
        end
      end
    end
  end

  // Receiver: stretches of different readiness, and a long hold-off on request.
  initial begin : receiver
    int seg_left;
    rx_mode_t mode;
    seg_left = 0;
    mode = RX_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        dst_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_count++;
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          RX_ALWAYS: dst_ready <= 1'b1;
          RX_HALF:   dst_ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: dst_ready <= ($urandom_range(0, 7) != 0);
          default:   dst_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((src_valid && src_ready) || (dst_valid && dst_ready)) stalled = 0;
      else stalled++;
    end
    $display("%0t: timeout, no transfer for %0d cycles, %0d output pixels outstanding",
             $time, STALL_LIMIT, expected_pixels.size());
    $display("testbench NOT OK");
    $finish;
  end

  // Offers one source pixel and returns at the edge of its transfer. Valid
  // stays high into the next item unless a gap between bursts is due.
  task automatic send_pixel(input logic [31:0] pix, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_valid <= 1'b1;
    pixel_in <= pix;
    frame_start <= fs;
    do @(posedge clk); while (!src_ready);
  endtask

  // Sends a run of random pixels; only the first one may carry frame_start.
  task automatic send_frame(input int n_pixels, input logic with_start);
    for (int i = 0; i < n_pixels; i++) send_pixel($urandom, with_start && (i == 0));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [13:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Stops the stream, lets the block empty, then writes all four sizes.
  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th);
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    // A pixel that selects nothing may still be inside the block.
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SOURCE_WIDTH, sw[13:0]);
    write_reg(REG_SOURCE_HEIGHT, sh[13:0]);
    write_reg(REG_TARGET_WIDTH, tw[13:0]);
    write_reg(REG_TARGET_HEIGHT, th[13:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Sizes after reset are 1920 by 1080 with no scaling: every pixel passes.
  task automatic test_reset_defaults();
    gap_max = 2;
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel($urandom, 1'b0);
  endtask

  // All sizes zero act as a 1x1 frame, so every pixel ends a row and a frame.
  task automatic test_zero_sizes();
    set_sizes(0, 0, 0, 0);
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
  endtask

  // All register bits set: sizes act as the dimension limit.
  task automatic test_oversize();
    set_sizes(16383, 16383, 16383, 16383);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel($urandom, 1'b0);
  endtask

  // Target larger than the source is clamped, so the frame passes unscaled.
  task automatic test_upscale_clamp();
    set_sizes(2, 2, 5, 9);
    send_frame(4, 1'b1);
  endtask

  // A frame start in the middle of a frame restarts the selection.
  task automatic test_frame_restart();
    set_sizes(3, 3, 2, 2);
    send_frame(4, 1'b1);
    send_frame(3, 1'b1);
  endtask

  // Shrinking the sizes mid-frame leaves the position beyond the new row end,
  // which must wrap on the next pixel.
  task automatic test_shrink_wrap();
    set_sizes(4, 4, 4, 4);
    send_frame(3, 1'b1);
    set_sizes(2, 2, 2, 2);
    send_frame(3, 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // pixels; with no scaling every pixel fills the block until src_ready drops.
  task automatic test_backpressure();
    set_sizes(6, 4, 6, 4);
    gap_max = 0;
    hold_req = 1'b1;
    send_frame(24, 1'b1);
    send_frame(24, 1'b1);
  endtask

  // Partial frames at the largest sizes; full frames there would be far too long.
  task automatic test_large_frames();
    gap_max = 3;
    set_sizes(MAX_DIM, 2, $urandom_range(MAX_DIM / 2, MAX_DIM), 2);
    send_frame(300, 1'b1);
    set_sizes(1, MAX_DIM, 1, $urandom_range(1, MAX_DIM));
    send_frame(300, 1'b1);
    set_sizes(MAX_DIM - 1, MAX_DIM - 1, $urandom_range(1, 8), $urandom_range(1, 8));
    send_frame(200, 1'b1);
  endtask

  // Random small sizes, mostly whole well-formed frames, with some cut frames,
  // frames without a start mark and unusual register values mixed in.
  task automatic test_random_frames(input int n_items);
    int sent;
    int unsigned sw, sh, tw, th;
    int eff_w, eff_h, n_frames, len;
    frame_kind_t kind;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        sw = $urandom_range(13, 40);
        sh = $urandom_range(1, 6);
      end else begin
        sw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
        sh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
      end
      eff_w = clamp_dim(sw[13:0], 15'(MAX_DIM));
      eff_h = clamp_dim(sh[13:0], 15'(MAX_DIM));
      case ($urandom_range(0, 9))
        0:       tw = 0;
        1:       tw = $urandom_range(eff_w, 16383);
        2:       tw = eff_w;
        default: tw = $urandom_range(1, eff_w);
      endcase
      case ($urandom_range(0, 9))
        0:       th = 0;
        1:       th = $urandom_range(eff_h, 16383);
        2:       th = eff_h;
        default: th = $urandom_range(1, eff_h);
      endcase
      set_sizes(sw, sh, tw, th);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      n_frames = $urandom_range(1, 4);
      for (int f = 0; f < n_frames; f++) begin
        case ($urandom_range(0, 19))
          16, 17:  kind = FRAME_CUT;
          18:      kind = FRAME_NO_START;
          19:      kind = FRAME_NO_START_CUT;
          default: kind = FRAME_FULL;
        endcase
        len = eff_w * eff_h;
        if (kind == FRAME_CUT || kind == FRAME_NO_START_CUT) len = $urandom_range(1, len);
        send_frame(len, (kind == FRAME_FULL || kind == FRAME_CUT));
        sent += len;
      end
    end
  endtask

  // Lets every expected pixel arrive, then reports the verdict.
  task automatic finish_run();
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d expected output pixels never arrived", $time,
               expected_pixels.size());
    end
    $display("Covered %0d source pixel transfers and %0d checked output pixels",
             pixels_accepted, results_checked);
    $display("(%0d row ends, %0d frame ends), %0d size settings, %0d receiver hold-offs.",
             rows_seen, frames_seen, settings_used, hold_count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_sizes();
    test_oversize();
    test_upscale_clamp();
    test_frame_restart();
    test_shrink_wrap();
    test_backpressure();
    test_large_frames();
    test_random_frames(950);
    finish_run();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
